### hdl/wfa_pkg.sv
// Package for the worst-fit heap allocator: heap geometry, header layout,
// datapath operation codes and the controller/datapath command and status structs.
// No dependencies.
package wfa_pkg;

	localparam int HEAP_BYTES   = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int AW           = $clog2(HEAP_BYTES);   // header memory index width
	localparam int TW           = AW + 1;               // offsets up to HEAP_BYTES
	localparam int NW           = 12;                   // request size width
	localparam int EW           = TW + 1;               // header entry: used flag + size

	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_FREE    = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_RD_P,
		DP_ALLOC_EV,
		DP_SPLIT1,
		DP_SPLIT2,
		DP_WHOLE,
		DP_APPEND,
		DP_FAIL,
		DP_RELEASE,
		DP_RD_F,
		DP_WR_F,
		DP_PSTEP,
		DP_MEV,
		DP_RD_Q,
		DP_QEV,
		DP_MWR,
		DP_PUSH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       p_lt_top;
		logic       q_lt_top;
		logic       data_used;
		logic       found;
		logic       fits_split;
		logic       append_fits;
		logic       free_ok;
	} status_t;

endpackage

### hdl/wfa_req_if.sv
// Request channel of the worst-fit heap allocator: valid/ready plus request payload.
// No dependencies.
interface wfa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [11:0] num_bytes;
	logic [12:0] block_addr;

	modport source (output valid, kind, num_bytes, block_addr, input ready);
	modport sink   (input valid, kind, num_bytes, block_addr, output ready);
endinterface

### hdl/wfa_rsp_if.sv
// Result channel of the worst-fit heap allocator: valid/ready plus result payload.
// No dependencies.
interface wfa_rsp_if;
	logic        valid;
	logic        ready;
	logic [12:0] addr;
	logic        ok;

	modport source (output valid, addr, ok, input ready);
	modport sink   (input valid, addr, ok, output ready);
endinterface

### hdl/worst_fit_heap_allocator_core.sv
// Worst-fit heap allocator core; one request at a time. An allocate walks every block in the
// heap and writes a second header when the block is split; a free walks the heap after
// the header write and merges each run of free neighbors. The result becomes valid in the
// same cycle that the next request can be taken; a result not yet taken holds back the next.
// Reset clears the heap top and the handshake state; header memory is not cleared.
module worst_fit_heap_allocator_core (
	input  logic  clk,
	input  logic  arst_n,
	wfa_req_if.sink   req,
	wfa_rsp_if.source rsp
);
	import wfa_pkg::*;

	cmd_t    cmd;
	status_t st;

	wfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	wfa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.kind       (req.kind),
		.num_bytes  (req.num_bytes),
		.block_addr (req.block_addr),
		.addr       (rsp.addr),
		.ok         (rsp.ok)
	);

endmodule

### hdl/wfa_ctrl.sv
// Controller state machine of the worst-fit heap allocator. Sequences the
// block walks and issues one datapath command per cycle. Depends on wfa_pkg.
module wfa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  wfa_pkg::status_t st,
	output wfa_pkg::cmd_t    cmd
);
	import wfa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_A_RD, S_A_EV, S_A_DEC, S_A_TAIL, S_F_RD, S_F_WR,
		S_M_RD, S_M_EV, S_M_QRD, S_M_QEV, S_M_WR, S_PUSH
	} state_t;

	state_t state_q, state_nx;
	logic   slot_free;

	assign req_ready = (state_q == S_IDLE);
	assign slot_free = !rsp_valid || rsp_ready;

	always_comb begin
		state_nx = state_q;
		cmd.op   = DP_NOP;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op   = DP_LOAD;
					state_nx = S_DISP;
				end
			end
			S_DISP: begin
				case (st.kind)
					KIND_ALLOC:   state_nx = S_A_RD;
					KIND_FREE:    state_nx = S_F_RD;
					KIND_RELEASE: begin
						cmd.op   = DP_RELEASE;
						state_nx = S_PUSH;
					end
					default: begin
						cmd.op   = DP_FAIL;
						state_nx = S_PUSH;
					end
				endcase
			end
			S_A_RD: begin
				if (st.p_lt_top) begin
					cmd.op   = DP_RD_P;
					state_nx = S_A_EV;
				end else begin
					state_nx = S_A_DEC;
				end
			end
			S_A_EV: begin
				cmd.op   = DP_ALLOC_EV;
				state_nx = S_A_RD;
			end
			S_A_DEC: begin
				if (st.found && st.fits_split) begin
					cmd.op   = DP_SPLIT1;
					state_nx = S_A_TAIL;
				end else if (st.found) begin
					cmd.op   = DP_WHOLE;
					state_nx = S_PUSH;
				end else if (st.append_fits) begin
					cmd.op   = DP_APPEND;
					state_nx = S_PUSH;
				end else begin
					cmd.op   = DP_FAIL;
					state_nx = S_PUSH;
				end
			end
			S_A_TAIL: begin
				cmd.op   = DP_SPLIT2;
				state_nx = S_PUSH;
			end
			S_F_RD: begin
				if (st.free_ok) begin
					cmd.op   = DP_RD_F;
					state_nx = S_F_WR;
				end else begin
					cmd.op   = DP_FAIL;
					state_nx = S_PUSH;
				end
			end
			S_F_WR: begin
				cmd.op   = DP_WR_F;
				state_nx = S_M_RD;
			end
			S_M_RD: begin
				if (st.p_lt_top) begin
					cmd.op   = DP_RD_P;
					state_nx = S_M_EV;
				end else begin
					state_nx = S_PUSH;
				end
			end
			S_M_EV: begin
				if (st.data_used) begin
					cmd.op   = DP_PSTEP;
					state_nx = S_M_RD;
				end else begin
					cmd.op   = DP_MEV;
					state_nx = S_M_QRD;
				end
			end
			S_M_QRD: begin
				if (st.q_lt_top) begin
					cmd.op   = DP_RD_Q;
					state_nx = S_M_QEV;
				end else begin
					state_nx = S_M_WR;
				end
			end
			S_M_QEV: begin
				if (!st.data_used) begin
					cmd.op   = DP_QEV;
					state_nx = S_M_QRD;
				end else begin
					state_nx = S_M_WR;
				end
			end
			S_M_WR: begin
				cmd.op   = DP_MWR;
				state_nx = S_M_RD;
			end
			S_PUSH: begin
				if (slot_free) begin
					cmd.op   = DP_PUSH;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.op == DP_PUSH) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

endmodule

### hdl/wfa_dp.sv
// Datapath of the worst-fit heap allocator: header memory, walk pointers,
// worst-fit tracking, heap top and the result register. Depends on wfa_pkg.
module wfa_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wfa_pkg::cmd_t              cmd,
	output wfa_pkg::status_t           st,
	input  logic [1:0]                 kind,
	input  logic [wfa_pkg::NW-1:0]     num_bytes,
	input  logic [wfa_pkg::TW-1:0]     block_addr,
	output logic [wfa_pkg::TW-1:0]     addr,
	output logic                       ok
);
	import wfa_pkg::*;

	localparam logic [TW-1:0] HDR  = TW'(HEADER_BYTES);
	localparam logic [TW:0]   HEAP = (TW + 1)'(HEAP_BYTES);

	logic [EW-1:0] mem [HEAP_BYTES];
	logic [EW-1:0] rd_data_q;

	logic [1:0]    kind_q;
	logic [NW-1:0] n_q;
	logic [TW-1:0] a_q;
	logic [TW-1:0] p_q, q_q, best_q, best_size_q, acc_q, top_q;
	logic          found_q;
	logic [TW-1:0] res_addr_q;
	logic          res_ok_q;

	logic [TW-1:0] d_size, n_ext, p_next, blk_step;
	logic          d_used;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [EW-1:0] wr_data;

	assign d_size   = rd_data_q[TW-1:0];
	assign d_used   = rd_data_q[EW-1];
	assign n_ext    = TW'(n_q);
	assign blk_step = HDR + d_size;
	assign p_next   = p_q + blk_step;

	assign st.kind        = kind_q;
	assign st.p_lt_top    = p_q < top_q;
	assign st.q_lt_top    = q_q < top_q;
	assign st.data_used   = d_used;
	assign st.found       = found_q;
	assign st.fits_split  = {1'b0, best_size_q} >= ({1'b0, n_ext} + (TW + 1)'(HEADER_BYTES + 1));
	assign st.append_fits = ({1'b0, top_q} + (TW + 1)'(HEADER_BYTES) + {1'b0, n_ext}) <= HEAP;
	assign st.free_ok     = (a_q >= HDR) && (a_q < top_q);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = p_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = best_q[AW-1:0];
		wr_data = {1'b1, n_ext};
		case (cmd.op)
			DP_RD_P: rd_en = 1'b1;
			DP_RD_Q: begin
				rd_en   = 1'b1;
				rd_addr = q_q[AW-1:0];
			end
			DP_RD_F: begin
				rd_en   = 1'b1;
				rd_addr = AW'(a_q - HDR);
			end
			DP_SPLIT1: wr_en = 1'b1;
			DP_SPLIT2: begin
				wr_en   = 1'b1;
				wr_addr = AW'(best_q + HDR + n_ext);
				wr_data = {1'b0, best_size_q - n_ext - HDR};
			end
			DP_WHOLE: begin
				wr_en   = 1'b1;
				wr_data = {1'b1, best_size_q};
			end
			DP_APPEND: begin
				wr_en   = 1'b1;
				wr_addr = top_q[AW-1:0];
			end
			DP_WR_F: begin
				wr_en   = 1'b1;
				wr_addr = AW'(a_q - HDR);
				wr_data = {1'b0, d_size};
			end
			DP_MWR: begin
				wr_en   = 1'b1;
				wr_addr = p_q[AW-1:0];
				wr_data = {1'b0, acc_q};
			end
			default: rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '0;
			found_q <= 1'b0;
		end else begin
			case (cmd.op)
				DP_LOAD:    found_q <= 1'b0;
				DP_APPEND:  top_q <= top_q + HDR + n_ext;
				DP_RELEASE: top_q <= '0;
				DP_ALLOC_EV: begin
					if (!d_used && (n_ext <= d_size) && (!found_q || d_size > best_size_q)) begin
						found_q <= 1'b1;
					end
				end
				default: found_q <= found_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				kind_q <= kind;
				n_q    <= num_bytes;
				a_q    <= block_addr;
				p_q    <= '0;
			end
			DP_ALLOC_EV: begin
				if (!d_used && (n_ext <= d_size) && (!found_q || d_size > best_size_q)) begin
					best_q      <= p_q;
					best_size_q <= d_size;
				end
				p_q <= p_next;
			end
			DP_SPLIT1, DP_WHOLE: begin
				res_addr_q <= best_q + HDR;
				res_ok_q   <= 1'b1;
			end
			DP_APPEND: begin
				res_addr_q <= top_q + HDR;
				res_ok_q   <= 1'b1;
			end
			DP_FAIL: begin
				res_addr_q <= '0;
				res_ok_q   <= 1'b0;
			end
			DP_RELEASE, DP_WR_F: begin
				res_addr_q <= '0;
				res_ok_q   <= 1'b1;
				p_q        <= '0;
			end
			DP_PSTEP: p_q <= p_next;
			DP_MEV: begin
				acc_q <= d_size;
				q_q   <= p_next;
			end
			DP_QEV: begin
				acc_q <= acc_q + blk_step;
				q_q   <= q_q + blk_step;
			end
			DP_MWR: p_q <= p_q + HDR + acc_q;
			DP_PUSH: begin
				addr <= res_addr_q;
				ok   <= res_ok_q;
			end
			default: p_q <= p_q;
		endcase
	end

endmodule

### sim/wfa_heap_checker.sv
`timescale 1ns / 1ps
// Checker for the worst-fit heap allocator: mirrors the block list and heap top,
// predicts each result when its request is accepted and compares accepted results.
// Depends on wfa_pkg, wfa_req_if and wfa_rsp_if.
module wfa_heap_checker (
	input  logic clk,
	input  logic arst_n,
	wfa_req_if   req,
	wfa_rsp_if   rsp,
	output int   fails,
	output int   pending
);
	import wfa_pkg::*;

	typedef struct packed {
		logic [12:0] addr;
		logic        ok;
	} alloc_result_t;

	logic        hdr_used [HEAP_BYTES];
	logic [12:0] hdr_size [HEAP_BYTES];
	int          top_q;
	alloc_result_t result_q[$];

	function automatic void merge_free_blocks();
		int p;
		int q;
		int sz;
		p = 0;
		while (p < top_q) begin
			sz = int'(hdr_size[p]);
			if (!hdr_used[p]) begin
				q = p + HEADER_BYTES + sz;
				while (q < top_q && !hdr_used[q]) begin
					sz += int'(hdr_size[q]) + HEADER_BYTES;
					q += int'(hdr_size[q]) + HEADER_BYTES;
				end
				hdr_used[p] = 1'b0;
				hdr_size[p] = 13'(sz);
			end
			p += HEADER_BYTES + sz;
		end
	endfunction

	function automatic alloc_result_t heap_outcome(logic [1:0] kind, int n, int a);
		alloc_result_t r;
		int p;
		int best;
		int best_sz;
		bit found;
		r = '0;
		case (kind)
			KIND_ALLOC: begin
				p = 0;
				best = 0;
				best_sz = 0;
				found = 0;
				// Worst fit: strictly larger wins, so the lowest block keeps a tie.
				while (p < top_q) begin
					if (!hdr_used[p] && n <= int'(hdr_size[p]) &&
						(!found || int'(hdr_size[p]) > best_sz)) begin
						found = 1;
						best = p;
						best_sz = int'(hdr_size[p]);
					end
					p += HEADER_BYTES + int'(hdr_size[p]);
				end
				if (found) begin
					hdr_used[best] = 1'b1;
					if (best_sz >= n + HEADER_BYTES + 1) begin
						hdr_size[best] = 13'(n);
						hdr_used[best + HEADER_BYTES + n] = 1'b0;
						hdr_size[best + HEADER_BYTES + n] = 13'(best_sz - n - HEADER_BYTES);
					end
					r.addr = 13'(best + HEADER_BYTES);
					r.ok = 1'b1;
				end else if (top_q + HEADER_BYTES + n <= HEAP_BYTES) begin
					hdr_used[top_q] = 1'b1;
					hdr_size[top_q] = 13'(n);
					r.addr = 13'(top_q + HEADER_BYTES);
					r.ok = 1'b1;
					top_q += HEADER_BYTES + n;
				end
			end
			KIND_FREE: begin
				if (a >= HEADER_BYTES && a < top_q) begin
					hdr_used[a - HEADER_BYTES] = 1'b0;
					merge_free_blocks();
					r.ok = 1'b1;
				end
			end
			KIND_RELEASE: begin
				top_q = 0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		fails++;
	endtask

	initial begin
		fails = 0;
		top_q = 0;
		for (int i = 0; i < HEAP_BYTES; i++) begin
			hdr_used[i] = 1'b0;
			hdr_size[i] = '0;
		end
	end

	assign pending = result_q.size();

	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n) begin
			if (req.valid && req.ready)
				result_q.push_back(heap_outcome(req.kind, int'(req.num_bytes),
					int'(req.block_addr)));
			if (rsp.valid && rsp.ready) begin
				if (result_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result addr=%0d ok=%0b",
						rsp.addr, rsp.ok));
				end else begin
					want = result_q.pop_front();
					if (rsp.addr !== want.addr)
						report_mismatch($sformatf("addr got %0d want %0d", rsp.addr, want.addr));
					if (rsp.ok !== want.ok)
						report_mismatch($sformatf("ok got %0b want %0b", rsp.ok, want.ok));
				end
			end
		end
	end
endmodule

### sim/worst_fit_heap_allocator_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the worst-fit heap allocator core: clock, reset, request
// stimulus with idle and stall phases, and the verdict. Depends on wfa_pkg,
// the channel interfaces, the core and wfa_heap_checker.
module worst_fit_heap_allocator_core_tb;
	import wfa_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fails;
	int   pending;
	int   idle_pct = 0;
	int   stall_pct = 0;
	// Payload offsets handed out so far; their headers are known to be written.
	int   handed_addrs[$];

	wfa_req_if req();
	wfa_rsp_if rsp();

	worst_fit_heap_allocator_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	wfa_heap_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.fails(fails),
		.pending(pending)
	);

	always #5 clk = ~clk;

	initial begin
		req.valid = 1'b0;
		req.kind = KIND_ALLOC;
		req.num_bytes = '0;
		req.block_addr = '0;
		rsp.ready = 1'b0;
	end

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= stall_pct);
		if (rsp.valid && rsp.ready && rsp.ok && rsp.addr != 0)
			handed_addrs.push_back(int'(rsp.addr));
	end

	task automatic send_request(logic [1:0] kind, int n, int a);
		// The sender stays idle for each cycle with the phase's idle chance.
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= kind;
		req.num_bytes <= 12'(n);
		req.block_addr <= 13'(a);
		do @(posedge clk); while (!req.ready);
	endtask

	function automatic int known_addr();
		if (handed_addrs.size() == 0)
			return $urandom_range(15);
		return handed_addrs[$urandom_range(handed_addrs.size() - 1)];
	endfunction

	task automatic random_request();
		int pick;
		pick = $urandom_range(99);
		if (pick < 55) begin
			if ($urandom_range(19) == 0)
				send_request(KIND_ALLOC, 0, $urandom_range(8191));
			else if ($urandom_range(14) == 0)
				send_request(KIND_ALLOC, $urandom_range(4080), $urandom_range(8191));
			else
				send_request(KIND_ALLOC, $urandom_range(120), $urandom_range(8191));
		end else if (pick < 93) begin
			send_request(KIND_FREE, $urandom_range(4095), known_addr());
		end else if (pick < 96) begin
			// Rejected frees: below a header or past any possible heap top.
			send_request(KIND_FREE, $urandom_range(4095),
				$urandom_range(1) ? $urandom_range(15) : $urandom_range(8191, 4096));
		end else if (pick < 98) begin
			send_request(KIND_RELEASE, $urandom_range(4095), $urandom_range(8191));
		end else begin
			send_request(KIND_UNUSED, $urandom_range(4095), $urandom_range(8191));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty heap, extremes, rejects, split, whole block, release.
		send_request(KIND_FREE, 0, 16);
		send_request(KIND_ALLOC, 0, 0);
		send_request(KIND_ALLOC, 4080, 0);
		send_request(KIND_ALLOC, 40, 0);
		send_request(KIND_ALLOC, 40, 0);
		send_request(KIND_FREE, 0, 0);
		send_request(KIND_FREE, 0, 15);
		send_request(KIND_FREE, 0, 8191);
		send_request(KIND_FREE, 0, 32);
		send_request(KIND_FREE, 0, 32);
		send_request(KIND_ALLOC, 8, 0);
		send_request(KIND_ALLOC, 10, 0);
		send_request(KIND_FREE, 0, 88);
		send_request(KIND_ALLOC, 2047, 0);
		send_request(KIND_UNUSED, 4095, 8191);
		send_request(KIND_RELEASE, 0, 0);
		send_request(KIND_ALLOC, 4080, 0);
		send_request(KIND_ALLOC, 0, 0);
		send_request(KIND_FREE, 0, 16);
		send_request(KIND_ALLOC, 4063, 0);
		send_request(KIND_FREE, 0, 16);
		send_request(KIND_ALLOC, 4064, 0);
		send_request(KIND_RELEASE, 0, 0);

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 81; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 81; end
				3: begin idle_pct = 22; stall_pct = 22; end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase
			repeat (305) random_request();
		end
		req.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
